### rtl/lzd_pkg.sv
package lzd_pkg;

  localparam int unsigned CntW = 24;
  localparam logic [CntW-1:0] CNT_MAX = '1;

  localparam logic [7:0] CFG_IDX_OFFSET_WIDTHS = 8'd0;
  localparam logic [7:0] CFG_IDX_OUT_SIZE      = 8'd1;

  localparam logic [2:0] ST_BYTE_OUT   = 3'd0;
  localparam logic [2:0] ST_NEED_INPUT = 3'd1;
  localparam logic [2:0] ST_ACCEPTED   = 3'd2;
  localparam logic [2:0] ST_REFUSED    = 3'd3;
  localparam logic [2:0] ST_FINISHED   = 3'd4;

  // decoder phase of the bitstream
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_FLAG   = 8'b0000_0010,
    PH_LITCNT = 8'b0000_0100,
    PH_LIT    = 8'b0000_1000,
    PH_CODE   = 8'b0001_0000,
    PH_OFFSET = 8'b0010_0000,
    PH_MCNT   = 8'b0100_0000,
    PH_COPY   = 8'b1000_0000
  } ph_e;

  // sequencer state of the back end
  typedef enum logic [4:0] {
    SQ_CLEAR = 5'b00001,
    SQ_IDLE  = 5'b00010,
    SQ_RUN   = 5'b00100,
    SQ_MOD   = 5'b01000,
    SQ_READ  = 5'b10000
  } sq_e;

  typedef struct packed {
    logic       step;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [39:0]     offset_widths;
    logic [CntW-1:0] out_size;
  } cfg_t;

endpackage

### rtl/lzd_if.sv
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;
  modport source(output valid, action, in_byte, input ready);
  modport sink(input valid, action, in_byte, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       last;
  modport source(output valid, status, out_byte, last, input ready);
  modport sink(input valid, status, out_byte, last, output ready);
endinterface

interface lzd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [39:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/lzd_ram.sv
module lzd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lzd_front.sv
module lzd_front
  import lzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lzd_in_if.sink      in_i,
  input  logic        busy_i,
  input  logic        pop_i,
  output logic        q_valid_o,
  output item_t       q_item_o
);

  item_t       mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_i.ready = (cnt_q != 2'd2) && !busy_i;
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{step: in_i.action, data: in_i.in_byte};
    end
  end

endmodule

### rtl/lzd_back.sv
module lzd_back
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  output logic        busy_o,
  lzd_out_if.source   out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] WLAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   WFULL = (AW+1)'(WINDOW_DEPTH);

  sq_e             sq_q, sq_d;
  ph_e             ph_q, ph_d;
  logic [7:0]      bbuf_q, bbuf_d;
  logic [3:0]      bleft_q, bleft_d;
  logic [15:0]     acc_q, acc_d;
  logic [4:0]      need_q, need_d;
  logic [2:0]      code_q, code_d;
  logic [15:0]     off_q, off_d;
  logic [CntW-1:0] run_q, run_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [AW-1:0]   wr_q, wr_d;
  logic [AW-1:0]   back_q, back_d;
  logic [16:0]     modv_q, modv_d;
  logic [3:0]      modk_q, modk_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            ov_q, ov_d;
  logic [2:0]      ost_q, ost_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;
  logic [AW:0]     rd_wide;
  logic [CntW:0]   sum;
  logic [CntW-1:0] run_dec, pos_inc;
  logic [24:0]     wshift;

  lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o         = (sq_q == SQ_CLEAR);
  assign out_o.valid    = ov_q;
  assign out_o.status   = ost_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.last     = olast_q;

  // copy source: write pointer minus distance, modulo the window
  assign rd_wide = ({1'b0, wr_q} >= {1'b0, back_q}) ? ({1'b0, wr_q} - {1'b0, back_q})
                                                     : ({1'b0, wr_q} + WFULL - {1'b0, back_q});
  assign raddr   = rd_wide[AW-1:0];
  assign sum     = {1'b0, run_q} + (CntW+1)'(acc_q);
  assign run_dec = (run_q != '0) ? run_q - 1'b1 : '0;
  assign pos_inc = pos_q + 1'b1;
  assign wshift  = 25'(WINDOW_DEPTH) << modk_q;

  always_comb begin
    sq_d    = sq_q;
    ph_d    = ph_q;
    bbuf_d  = bbuf_q;
    bleft_d = bleft_q;
    acc_d   = acc_q;
    need_d  = need_q;
    code_d  = code_q;
    off_d   = off_q;
    run_d   = run_q;
    pos_d   = pos_q;
    wr_d    = wr_q;
    back_d  = back_q;
    modv_d  = modv_q;
    modk_d  = modk_q;
    clr_d   = clr_q;
    ov_d    = ov_q && !out_o.ready;
    ost_d   = ost_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = wr_q;
    wdata   = 8'd0;
    re      = 1'b0;

    case (sq_q)
      SQ_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == WLAST) begin
          sq_d = SQ_IDLE;
        end
      end
      SQ_IDLE: begin
        // the result word leaving this cycle frees the output register
        if (q_valid_i && (!ov_q || out_o.ready)) begin
          pop_o   = 1'b1;
          obyte_d = 8'd0;
          olast_d = 1'b0;
          if (!q_item_i.step) begin
            ov_d = 1'b1;
            if (bleft_q == 4'd0) begin
              bbuf_d  = q_item_i.data;
              bleft_d = 4'd8;
              ost_d   = ST_ACCEPTED;
            end else begin
              ost_d = ST_REFUSED;
            end
          end else if (pos_q >= cfg_i.out_size) begin
            ov_d  = 1'b1;
            ost_d = ST_FINISHED;
          end else begin
            sq_d = SQ_RUN;
          end
        end
      end
      SQ_RUN: begin
        if (ph_q == PH_COPY) begin
          re   = 1'b1;
          sq_d = SQ_READ;
        end else if (need_q != 5'd0) begin
          if (bleft_q == 4'd0) begin
            ov_d  = 1'b1;
            ost_d = ST_NEED_INPUT;
            sq_d  = SQ_IDLE;
          end else begin
            acc_d   = {acc_q[14:0], bbuf_q[7]};
            bbuf_d  = {bbuf_q[6:0], 1'b0};
            bleft_d = bleft_q - 1'b1;
            need_d  = need_q - 1'b1;
          end
        end else begin
          acc_d = 16'd0;
          case (ph_q)
            PH_IDLE: begin
              ph_d   = PH_FLAG;
              need_d = 5'd1;
            end
            PH_FLAG: begin
              if (acc_q != 16'd0) begin
                ph_d   = PH_LITCNT;
                run_d  = CntW'(1);
                need_d = 5'd2;
              end else begin
                ph_d   = PH_CODE;
                need_d = 5'd3;
              end
            end
            PH_LITCNT: begin
              run_d = sum[CntW] ? CNT_MAX : sum[CntW-1:0];
              if (acc_q == 16'd3) begin
                need_d = 5'd2;
              end else begin
                ph_d   = PH_LIT;
                need_d = 5'd8;
              end
            end
            PH_LIT: begin
              we      = 1'b1;
              wdata   = acc_q[7:0];
              pos_d   = pos_inc;
              wr_d    = (pos_q == CNT_MAX || wr_q == WLAST) ? '0 : wr_q + 1'b1;
              ov_d    = 1'b1;
              ost_d   = ST_BYTE_OUT;
              obyte_d = acc_q[7:0];
              olast_d = (pos_inc == cfg_i.out_size);
              run_d   = run_dec;
              sq_d    = SQ_IDLE;
              if (run_dec == '0) begin
                ph_d   = PH_CODE;
                need_d = 5'd3;
              end else begin
                need_d = 5'd8;
              end
            end
            PH_CODE: begin
              code_d = acc_q[2:0];
              ph_d   = PH_OFFSET;
              need_d = cfg_i.offset_widths[5*acc_q[2:0] +: 5];
            end
            PH_OFFSET: begin
              off_d  = acc_q;
              modv_d = {1'b0, acc_q} + 17'd1;
              modk_d = 4'd8;
              sq_d   = SQ_MOD;
              if (code_q[1:0] == 2'd0) begin
                ph_d   = PH_MCNT;
                run_d  = CntW'(5);
                need_d = 5'd3;
              end else begin
                ph_d  = PH_COPY;
                run_d = CntW'(code_q[1:0]) + 1'b1;
              end
            end
            PH_MCNT: begin
              run_d = sum[CntW] ? CNT_MAX : sum[CntW-1:0];
              if (acc_q == 16'd7) begin
                need_d = 5'd3;
              end else begin
                ph_d = PH_COPY;
              end
            end
            default: begin
              ph_d = PH_IDLE;
            end
          endcase
        end
      end
      SQ_MOD: begin
        // restoring reduction of the copy distance by the window size
        if ({8'd0, modv_q} >= wshift) begin
          modv_d = modv_q - wshift[16:0];
        end
        if (modk_q == 4'd0) begin
          back_d = AW'(({8'd0, modv_q} >= wshift) ? modv_q - wshift[16:0] : modv_q);
          sq_d   = SQ_RUN;
        end else begin
          modk_d = modk_q - 1'b1;
        end
      end
      SQ_READ: begin
        we      = 1'b1;
        wdata   = rdata;
        pos_d   = pos_inc;
        wr_d    = (pos_q == CNT_MAX || wr_q == WLAST) ? '0 : wr_q + 1'b1;
        ov_d    = 1'b1;
        ost_d   = ST_BYTE_OUT;
        obyte_d = rdata;
        olast_d = (pos_inc == cfg_i.out_size);
        run_d   = run_dec;
        if (run_dec == '0) begin
          ph_d = PH_IDLE;
        end
        sq_d = SQ_IDLE;
      end
      default: begin
        sq_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q    <= SQ_CLEAR;
      ph_q    <= PH_IDLE;
      bbuf_q  <= '0;
      bleft_q <= '0;
      acc_q   <= '0;
      need_q  <= '0;
      code_q  <= '0;
      off_q   <= '0;
      run_q   <= '0;
      pos_q   <= '0;
      wr_q    <= '0;
      back_q  <= '0;
      modv_q  <= '0;
      modk_q  <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      sq_q    <= sq_d;
      ph_q    <= ph_d;
      bbuf_q  <= bbuf_d;
      bleft_q <= bleft_d;
      acc_q   <= acc_d;
      need_q  <= need_d;
      code_q  <= code_d;
      off_q   <= off_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
      wr_q    <= wr_d;
      back_q  <= back_d;
      modv_q  <= modv_d;
      modk_q  <= modk_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q   <= ost_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

### rtl/lz77_bitstream_decompressor.sv
// LZ77 bitstream decompressor. Each input word is either a feed of one
// compressed byte or a step; each gives exactly one result word. Words enter
// a two-deep queue and are carried out one at a time by the decoder, which
// takes one stream bit per cycle. A feed is loaded into the bit buffer, a
// literal byte is shifted in bit by bit, a copied byte is read from the
// history (the read is registered), and a new match takes its field bits
// and then reduces the distance by the window size. After reset the history
// RAM is cleared, one entry a cycle, and no input word is taken until it is
// done; configuration writes are taken at any time.
module lz77_bitstream_decompressor
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzd_in_if.sink    in_i,
  lzd_cfg_if.sink   cfg_i,
  lzd_out_if.source out_o
);

  cfg_t  cfg_q, cfg_d;
  logic  q_valid, pop, busy;
  item_t q_item;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IDX_OFFSET_WIDTHS: cfg_d.offset_widths = cfg_i.data;
        CFG_IDX_OUT_SIZE:      cfg_d.out_size      = cfg_i.data[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lzd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .busy_i    (busy),
    .pop_i     (pop),
    .q_valid_o (q_valid),
    .q_item_o  (q_item)
  );

  lzd_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .busy_o    (busy),
    .out_o     (out_o)
  );

endmodule
